FILE: src/bca_pkg.sv
package bca_pkg;

   localparam int CHUNK_BYTES   = 16;
   localparam int CB_SHIFT      = $clog2(CHUNK_BYTES);
   localparam int MAX_CHUNKS    = 8;
   localparam int HEADER_CHUNKS = 4;
   localparam int MAX_BYTES     = MAX_CHUNKS * CHUNK_BYTES;

   localparam int CMD_W  = 2;
   localparam int SIZE_W = 12;
   localparam int OFF_W  = 14;
   localparam int STAT_W = 3;
   localparam int CNT_W  = 4;
   localparam int IDX_W  = OFF_W - CB_SHIFT;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_RESIZE = 2'd2,
      CMD_BAD    = 2'd3
   } command_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK         = 3'd0,
      ST_NOSPACE    = 3'd1,
      ST_MISALIGNED = 3'd2,
      ST_NOTALLOC   = 3'd3,
      ST_MOVE       = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_SRCH_RD, S_SRCH_CHK, S_EXT_RD0, S_EXT_RD1,
      S_EXT_CHK, S_APP_RD, S_APP_WR, S_DONE
   } state_type;

   // one memory word: 64 chunks of start and in-use bits
   typedef struct packed {
      logic [63:0] start;
      logic [63:0] in_use;
   } map_word_type;

endpackage

FILE: src/bca_ifs.sv
interface bca_req_if;
   import bca_pkg::*;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [SIZE_W-1:0] size_bytes;
   logic [OFF_W-1:0]  byte_offset;
   modport source(output valid, command, size_bytes, byte_offset, input ready);
   modport sink(input valid, command, size_bytes, byte_offset, output ready);
endinterface

interface bca_rsp_if;
   import bca_pkg::*;
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [OFF_W-1:0]  result_offset;
   logic [CNT_W-1:0]  chunk_count;
   logic              zone_empty;
   modport source(output valid, status, result_offset, chunk_count, zone_empty,
                  input ready);
   modport sink(input valid, status, result_offset, chunk_count, zone_empty,
                output ready);
endinterface

FILE: src/bitmap_chunk_allocator_top.sv
// Sequence after a request is accepted: allocate reads and checks one map word at a time
//   from the search start, then updates the map (two words if the run spans two words).
//   Free / resize read the extent, then update the map unless no map write is needed.
//   Errors found at dispatch go straight to the result.
// One word in flight; the next request is taken in the cycle the result turns valid.
// Reset: synchronous; after reset a clearing pass writes every map word to zero,
//   one word per cycle, before the first request is taken.
module bitmap_chunk_allocator_top #(
   parameter int NUM_CHUNKS = 1024
) (
   input logic       clock,
   input logic       reset,
   bca_req_if.sink   req_chan,
   bca_rsp_if.source rsp_chan
);
   import bca_pkg::*;

   localparam int MAP_WORDS = (NUM_CHUNKS + 63) / 64;
   localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int CW        = $clog2(NUM_CHUNKS) + 1;   // chunk positions below 2N
   localparam int HW        = $clog2(NUM_CHUNKS);
   localparam int UW        = $clog2(NUM_CHUNKS + 1);
   localparam int PW        = (CW + CB_SHIFT > OFF_W) ? CW + CB_SHIFT : OFF_W;
   localparam int LAST_BITS = NUM_CHUNKS - (MAP_WORDS - 1) * 64;
   localparam logic [63:0] LAST_MASK = {64{1'b1}} >> (64 - LAST_BITS);

   // FSM and work registers
   state_type         state_ff, state_in;
   logic [WW-1:0]     init_cnt_ff, init_cnt_in;
   logic [HW-1:0]     hint_ff, hint_in;          // first-fit lower bound
   logic [UW-1:0]     used_ff, used_in;          // chunks in use, gives empty flag
   logic [CNT_W-1:0]  n_ff, n_in;                // requested chunks
   logic [SIZE_W-1:0] size_ff, size_in;
   logic              is_free_ff, is_free_in;
   logic [WW-1:0]     w_ff, w_in;                // search word
   logic [HW-1:0]     start_ff, start_in;        // search start chunk
   logic              first_ff, first_in;
   logic [MAX_CHUNKS-2:0] carry_ff, carry_in;    // free tail of previous word
   logic [CW-1:0]     idx_ff, idx_in;
   map_word_type      lo_ff, lo_in;              // word holding idx

   // pending bitmap update: range [a, a+len), set or clear, and start bit at a
   logic [CW-1:0]     a_ff, a_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic              set_ff, set_in;
   logic              st_mod_ff, st_mod_in;
   logic              st_val_ff, st_val_in;
   logic [WW-1:0]     aw_ff, aw_in;
   logic              second_ff, second_in;

   // result held until the output register is free
   status_type        res_st_ff, res_st_in;
   logic [OFF_W-1:0]  res_off_ff, res_off_in;
   logic [CNT_W-1:0]  res_cnt_ff, res_cnt_in;
   logic              res_emp_ff, res_emp_in;

   // output register
   logic              out_v_ff, out_v_in;
   status_type        out_st_ff, out_st_in;
   logic [OFF_W-1:0]  out_off_ff, out_off_in;
   logic [CNT_W-1:0]  out_cnt_ff, out_cnt_in;
   logic              out_emp_ff, out_emp_in;

   // memory port
   logic [WW-1:0]     rd_addr;
   map_word_type      rd_data;
   logic              wr_en;
   logic [WW-1:0]     wr_addr;
   map_word_type      wr_data;

   bca_map_mem #(.DEPTH(MAP_WORDS), .AW(WW)) u_mem (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // request decode
   logic              req_take;
   logic [IDX_W-1:0]  req_idx;
   logic [SIZE_W:0]   req_ceil;
   logic [CNT_W-1:0]  req_n;
   logic [HW-1:0]     srch_start;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign req_idx        = req_chan.byte_offset[OFF_W-1:CB_SHIFT];
   assign req_ceil       = ({1'b0, req_chan.size_bytes} + (SIZE_W+1)'(CHUNK_BYTES - 1))
                           >> CB_SHIFT;
   assign req_n          = (req_ceil == '0) ? CNT_W'(1) : req_ceil[CNT_W-1:0];
   assign srch_start     = (32'(hint_ff) < HEADER_CHUNKS) ? HW'(HEADER_CHUNKS) : hint_ff;

   // search window: a run of n free chunks ending at bit j
   logic [63:0]               free_bits;
   logic [63+MAX_CHUNKS-1:0]  ext;
   logic [63:0]               fits;
   logic                      hit;
   logic [5:0]                hit_j;
   logic [CW-1:0]             pos;

   always_comb begin
      free_bits = ~rd_data.in_use
                & ((w_ff == WW'(MAP_WORDS - 1)) ? LAST_MASK : {64{1'b1}})
                & (first_ff ? ({64{1'b1}} << start_ff[5:0]) : {64{1'b1}});
      ext = {free_bits, carry_ff};
      for (int j = 0; j < 64; j++) begin
         fits[j] = 1'b1;
         for (int k = 0; k < MAX_CHUNKS; k++) begin
            if (k < int'(n_ff) && !ext[j + MAX_CHUNKS - 1 - k]) begin
               fits[j] = 1'b0;
            end
         end
      end
      hit   = |fits;
      hit_j = '0;
      for (int j = 63; j >= 0; j--) begin
         if (fits[j]) begin
            hit_j = 6'(j);
         end
      end
      pos = CW'({w_ff, 6'b0}) + CW'(hit_j) + CW'(1) - CW'(n_ff);
   end

   // extent window around idx
   logic              have_hi;
   map_word_type      hi_word;
   logic [127:0]      use_win, st_win;
   logic [CNT_W-1:0]  old_cnt;
   logic              alive, blocked;

   always_comb begin
      have_hi = (32'(idx_ff >> 6) + 1) < MAP_WORDS;
      hi_word = have_hi ? rd_data : '0;
      use_win = {hi_word.in_use, lo_ff.in_use} >> idx_ff[5:0];
      st_win  = {hi_word.start, lo_ff.start} >> idx_ff[5:0];
      old_cnt = CNT_W'(1);
      alive   = 1'b1;
      for (int k = 1; k < MAX_CHUNKS; k++) begin
         alive = alive && use_win[k] && !st_win[k] && ((32'(idx_ff) + k) < NUM_CHUNKS);
         if (alive) begin
            old_cnt = CNT_W'(k + 1);
         end
      end
      blocked = 1'b0;
      for (int k = 0; k < MAX_CHUNKS; k++) begin
         if (k >= int'(old_cnt) && k < int'(n_ff) &&
             (use_win[k] || (32'(idx_ff) + k) >= NUM_CHUNKS)) begin
            blocked = 1'b1;
         end
      end
   end

   // update masks
   logic [64:0]  len_full;
   logic [127:0] rng_mask, st_mask;
   logic [63:0]  m_word, s_word;

   always_comb begin
      len_full = (65'd1 << len_ff) - 65'd1;
      rng_mask = {64'b0, len_full[63:0]} << a_ff[5:0];
      st_mask  = 128'd1 << a_ff[5:0];
      m_word   = second_ff ? rng_mask[127:64] : rng_mask[63:0];
      s_word   = second_ff ? 64'b0 : st_mask[63:0];
   end

   logic [PW-1:0] pos_bytes;
   assign pos_bytes = PW'(pos) << CB_SHIFT;

   always_comb begin
      state_in    = state_ff;
      init_cnt_in = init_cnt_ff;
      hint_in     = hint_ff;
      used_in     = used_ff;
      n_in        = n_ff;
      size_in     = size_ff;
      is_free_in  = is_free_ff;
      w_in        = w_ff;
      start_in    = start_ff;
      first_in    = first_ff;
      carry_in    = carry_ff;
      idx_in      = idx_ff;
      lo_in       = lo_ff;
      a_in        = a_ff;
      len_in      = len_ff;
      set_in      = set_ff;
      st_mod_in   = st_mod_ff;
      st_val_in   = st_val_ff;
      aw_in       = aw_ff;
      second_in   = second_ff;
      res_st_in   = res_st_ff;
      res_off_in  = res_off_ff;
      res_cnt_in  = res_cnt_ff;
      res_emp_in  = res_emp_ff;
      out_v_in    = out_v_ff && !rsp_chan.ready;
      out_st_in   = out_st_ff;
      out_off_in  = out_off_ff;
      out_cnt_in  = out_cnt_ff;
      out_emp_in  = out_emp_ff;
      rd_addr     = '0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;

      case (state_ff)
         S_INIT: begin
            wr_en       = 1'b1;
            wr_addr     = init_cnt_ff;
            init_cnt_in = init_cnt_ff + WW'(1);
            if (init_cnt_ff == WW'(MAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               size_in    = req_chan.size_bytes;
               n_in       = req_n;
               res_off_in = req_chan.byte_offset;
               res_cnt_in = '0;
               res_emp_in = 1'b0;
               is_free_in = (command_type'(req_chan.command) == CMD_FREE);
               state_in   = S_DONE;
               if (command_type'(req_chan.command) == CMD_ALLOC) begin
                  res_off_in = '0;
                  if (32'(req_chan.size_bytes) > MAX_BYTES) begin
                     res_st_in = ST_NOSPACE;
                  end else begin
                     start_in = srch_start;
                     w_in     = WW'(srch_start >> 6);
                     first_in = 1'b1;
                     carry_in = '0;
                     state_in = S_SRCH_RD;
                  end
               end else if (command_type'(req_chan.command) == CMD_BAD) begin
                  res_st_in = ST_NOTALLOC;
               end else if (req_chan.byte_offset[CB_SHIFT-1:0] != '0) begin
                  res_st_in = ST_MISALIGNED;
               end else if (32'(req_idx) >= NUM_CHUNKS) begin
                  res_st_in = ST_NOTALLOC;
               end else begin
                  idx_in   = CW'(req_idx);
                  state_in = S_EXT_RD0;
               end
            end
         end
         S_SRCH_RD: begin
            rd_addr  = w_ff;
            state_in = S_SRCH_CHK;
         end
         S_SRCH_CHK: begin
            if (hit) begin
               a_in       = pos;
               len_in     = n_ff;
               set_in     = 1'b1;
               st_mod_in  = 1'b1;
               st_val_in  = 1'b1;
               aw_in      = WW'(pos >> 6);
               second_in  = 1'b0;
               used_in    = used_ff + UW'(n_ff);
               if (pos < CW'(hint_ff)) begin
                  hint_in = HW'(pos);
               end
               res_st_in  = ST_OK;
               res_off_in = pos_bytes[OFF_W-1:0];
               res_cnt_in = n_ff;
               state_in   = S_APP_RD;
            end else if (w_ff == WW'(MAP_WORDS - 1)) begin
               res_st_in = ST_NOSPACE;
               state_in  = S_DONE;
            end else begin
               w_in     = w_ff + WW'(1);
               first_in = 1'b0;
               carry_in = free_bits[63 -: (MAX_CHUNKS - 1)];
               state_in = S_SRCH_RD;
            end
         end
         S_EXT_RD0: begin
            rd_addr  = WW'(idx_ff >> 6);
            state_in = S_EXT_RD1;
         end
         S_EXT_RD1: begin
            lo_in    = rd_data;
            rd_addr  = WW'((idx_ff >> 6) + CW'(1));
            state_in = S_EXT_CHK;
         end
         S_EXT_CHK: begin
            state_in  = S_DONE;
            a_in      = idx_ff;
            aw_in     = WW'(idx_ff >> 6);
            second_in = 1'b0;
            st_mod_in = 1'b0;
            st_val_in = 1'b0;
            if (!use_win[0] || !st_win[0]) begin
               res_st_in = ST_NOTALLOC;
            end else if (is_free_ff) begin
               len_in     = old_cnt;
               set_in     = 1'b0;
               st_mod_in  = 1'b1;
               used_in    = used_ff - UW'(old_cnt);
               if (idx_ff < CW'(hint_ff)) begin
                  hint_in = HW'(idx_ff);
               end
               res_st_in  = ST_OK;
               res_emp_in = (used_ff == UW'(old_cnt));
               state_in   = S_APP_RD;
            end else if (32'(size_ff) > MAX_BYTES) begin
               res_st_in  = ST_MOVE;
               res_cnt_in = old_cnt;
            end else if (n_ff < old_cnt) begin
               // shrink: drop the tail
               a_in       = idx_ff + CW'(n_ff);
               aw_in      = WW'((idx_ff + CW'(n_ff)) >> 6);
               len_in     = old_cnt - n_ff;
               set_in     = 1'b0;
               used_in    = used_ff - UW'(old_cnt - n_ff);
               if ((idx_ff + CW'(n_ff)) < CW'(hint_ff)) begin
                  hint_in = HW'(idx_ff + CW'(n_ff));
               end
               res_st_in  = ST_OK;
               res_cnt_in = n_ff;
               state_in   = S_APP_RD;
            end else if (n_ff == old_cnt) begin
               res_st_in  = ST_OK;
               res_cnt_in = n_ff;
            end else if (blocked) begin
               res_st_in  = ST_MOVE;
               res_cnt_in = old_cnt;
            end else begin
               // grow in place
               a_in       = idx_ff + CW'(old_cnt);
               aw_in      = WW'((idx_ff + CW'(old_cnt)) >> 6);
               len_in     = n_ff - old_cnt;
               set_in     = 1'b1;
               used_in    = used_ff + UW'(n_ff - old_cnt);
               res_st_in  = ST_OK;
               res_cnt_in = n_ff;
               state_in   = S_APP_RD;
            end
         end
         S_APP_RD: begin
            rd_addr  = aw_ff;
            state_in = S_APP_WR;
         end
         S_APP_WR: begin
            wr_en          = 1'b1;
            wr_addr        = aw_ff;
            wr_data.in_use = set_ff ? (rd_data.in_use | m_word) : (rd_data.in_use & ~m_word);
            wr_data.start  = rd_data.start;
            if (st_mod_ff) begin
               wr_data.start = st_val_ff ? (rd_data.start | s_word)
                                         : (rd_data.start & ~s_word);
            end
            if (!second_ff && rng_mask[127:64] != '0) begin
               second_in = 1'b1;
               aw_in     = aw_ff + WW'(1);
               state_in  = S_APP_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!out_v_ff || rsp_chan.ready) begin
               out_v_in   = 1'b1;
               out_st_in  = res_st_ff;
               out_off_in = res_off_ff;
               out_cnt_in = res_cnt_ff;
               out_emp_in = res_emp_ff;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_INIT;
         init_cnt_ff <= '0;
         hint_ff     <= HW'(HEADER_CHUNKS);
         used_ff     <= '0;
         out_v_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         init_cnt_ff <= init_cnt_in;
         hint_ff     <= hint_in;
         used_ff     <= used_in;
         out_v_ff    <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      size_ff    <= size_in;
      is_free_ff <= is_free_in;
      w_ff       <= w_in;
      start_ff   <= start_in;
      first_ff   <= first_in;
      carry_ff   <= carry_in;
      idx_ff     <= idx_in;
      lo_ff      <= lo_in;
      a_ff       <= a_in;
      len_ff     <= len_in;
      set_ff     <= set_in;
      st_mod_ff  <= st_mod_in;
      st_val_ff  <= st_val_in;
      aw_ff      <= aw_in;
      second_ff  <= second_in;
      res_st_ff  <= res_st_in;
      res_off_ff <= res_off_in;
      res_cnt_ff <= res_cnt_in;
      res_emp_ff <= res_emp_in;
      out_st_ff  <= out_st_in;
      out_off_ff <= out_off_in;
      out_cnt_ff <= out_cnt_in;
      out_emp_ff <= out_emp_in;
   end

   assign rsp_chan.valid         = out_v_ff;
   assign rsp_chan.status        = out_st_ff;
   assign rsp_chan.result_offset = out_off_ff;
   assign rsp_chan.chunk_count   = out_cnt_ff;
   assign rsp_chan.zone_empty    = out_emp_ff;
endmodule

FILE: src/bca_map_mem.sv
module bca_map_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                  clock,
   input  logic [AW-1:0]         rd_addr,
   output bca_pkg::map_word_type rd_data,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  bca_pkg::map_word_type wr_data
);
   import bca_pkg::*;

   map_word_type mem [DEPTH];
   map_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: src/bca_checker.sv
module bca_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [bca_pkg::STAT_W-1:0] status,
   input logic [bca_pkg::OFF_W-1:0]  result_offset,
   input logic [bca_pkg::CNT_W-1:0]  chunk_count,
   input logic                       zone_empty
);
   import bca_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(chunk_count))
      else $error("response word dropped or changed while stalled");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && zone_empty |-> status == ST_OK && chunk_count == '0)
      else $error("empty flag on a word that is not a good free");

   a_nospace: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == ST_NOSPACE |-> result_offset == '0 && chunk_count == '0)
      else $error("no-space word carries offset or count");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(chunk_count) <= MAX_CHUNKS)
      else $error("chunk count above class limit");
endmodule

bind bitmap_chunk_allocator_top bca_checker u_bca_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .status        (rsp_chan.status),
   .result_offset (rsp_chan.result_offset),
   .chunk_count   (rsp_chan.chunk_count),
   .zone_empty    (rsp_chan.zone_empty)
);

FILE: verif/tb_bitmap_chunk_allocator_top.sv
module tb_bitmap_chunk_allocator_top;
   import bca_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NCH = 1024;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [SIZE_W-1:0] size_bytes;
      logic [OFF_W-1:0]  byte_offset;
   } req_word_t;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [OFF_W-1:0]  result_offset;
      logic [CNT_W-1:0]  chunk_count;
      logic              zone_empty;
   } rsp_word_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bca_req_if req_chan();
   bca_rsp_if rsp_chan();

   bitmap_chunk_allocator_top #(.NUM_CHUNKS(NCH)) i_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   always #5 clock = ~clock;

   // shadow allocator state
   logic [NCH-1:0] used_bits;
   logic [NCH-1:0] start_bits;
   int unsigned    hint;

   req_word_t pending_reqs[$];
   rsp_word_t expected_rsps[$];
   int unsigned live_offsets[$];  // offsets of allocations believed live

   int  error_count = 0;
   int  send_idle_pct = 11;
   int  recv_idle_pct = 63;
   bit  hold_rsp;
   bit  stall_go = 1'b0;
   int  hold_count;
   int  quiet_cycles = 0;

   function automatic bit used_at(int unsigned i);
      return (i < NCH) ? used_bits[i] : 1'b0;
   endfunction

   function automatic bit start_at(int unsigned i);
      return (i < NCH) ? start_bits[i] : 1'b0;
   endfunction

   function automatic int unsigned chunks_needed(int unsigned bytes);
      int unsigned n;
      n = (bytes + CHUNK_BYTES - 1) / CHUNK_BYTES;
      return (n == 0) ? 1 : n;
   endfunction

   // compute one response and advance the shadow state
   function automatic rsp_word_t allocator_predict(req_word_t r);
      rsp_word_t   o;
      int unsigned n, idx, old, run, pos, i;
      bit          found, blocked;
      o = '0;
      o.result_offset = r.byte_offset;
      if (r.command == CMD_ALLOC) begin
         o.result_offset = '0;
         o.status = ST_NOSPACE;
         if (r.size_bytes <= MAX_BYTES) begin
            n = chunks_needed(r.size_bytes);
            run = 0;
            found = 1'b0;
            pos = 0;
            for (i = (hint < HEADER_CHUNKS) ? HEADER_CHUNKS : hint; i < NCH && !found; i++) begin
               if (used_bits[i]) run = 0;
               else begin
                  run++;
                  if (run == n) begin
                     found = 1'b1;
                     pos = i + 1 - n;
                  end
               end
            end
            if (found) begin
               for (i = 0; i < n; i++) used_bits[pos+i] = 1'b1;
               start_bits[pos] = 1'b1;
               if (pos < hint) hint = pos;
               o.status = ST_OK;
               o.result_offset = OFF_W'(pos * CHUNK_BYTES);
               o.chunk_count = CNT_W'(n);
            end
         end
         return o;
      end
      if (r.command == CMD_BAD) begin
         o.status = ST_NOTALLOC;
         return o;
      end
      if (r.byte_offset % CHUNK_BYTES != 0) begin
         o.status = ST_MISALIGNED;
         return o;
      end
      idx = r.byte_offset / CHUNK_BYTES;
      if (idx >= NCH || !used_at(idx) || !start_at(idx)) begin
         o.status = ST_NOTALLOC;
         return o;
      end
      old = 1;
      while (old < MAX_CHUNKS && idx + old < NCH && used_at(idx + old)
             && !start_at(idx + old)) old++;
      if (r.command == CMD_FREE) begin
         for (i = 0; i < old; i++) used_bits[idx+i] = 1'b0;
         start_bits[idx] = 1'b0;
         if (idx < hint) hint = idx;
         o.status = ST_OK;
         o.zone_empty = (used_bits == '0);
         return o;
      end
      // resize
      o.status = ST_MOVE;
      o.chunk_count = CNT_W'(old);
      if (r.size_bytes > MAX_BYTES) return o;
      n = chunks_needed(r.size_bytes);
      if (n < old) begin
         for (i = idx + n; i < idx + old; i++) used_bits[i] = 1'b0;
         if (idx + n < hint) hint = idx + n;
         o.status = ST_OK;
         o.chunk_count = CNT_W'(n);
         return o;
      end
      blocked = 1'b0;
      for (i = idx + old; i < idx + n; i++)
         if (i >= NCH || used_at(i)) blocked = 1'b1;
      if (blocked) return o;
      for (i = idx + old; i < idx + n; i++) used_bits[i] = 1'b1;
      o.status = ST_OK;
      o.chunk_count = CNT_W'(n);
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   function automatic req_word_t mk(command_type c, int unsigned sz, int unsigned off);
      req_word_t r;
      r.command = c;
      r.size_bytes = SIZE_W'(sz);
      r.byte_offset = OFF_W'(off);
      return r;
   endfunction

   // generation keeps a rough view of live blocks so frees hit real starts
   function automatic req_word_t random_req();
      int unsigned k, p, off;
      p = $urandom_range(99);
      if (p < 8) begin
         // noise: any field pattern at all
         return mk(command_type'($urandom_range(3)), $urandom_range(4095),
                   $urandom_range(16383));
      end
      if (p < 50 || live_offsets.size() == 0) begin
         return mk(CMD_ALLOC, ($urandom_range(9) == 0) ? $urandom_range(4095)
                              : $urandom_range(MAX_BYTES), 0);
      end
      k = $urandom_range(live_offsets.size() - 1);
      off = live_offsets[k];
      if ($urandom_range(15) == 0) off = off ^ (1 << $urandom_range(OFF_W - 1));
      if (p < 78) begin
         live_offsets.delete(k);
         return mk(CMD_FREE, $urandom_range(4095), off);
      end
      return mk(CMD_RESIZE, ($urandom_range(9) == 0) ? $urandom_range(4095)
                            : $urandom_range(MAX_BYTES), off);
   endfunction

   // driver: offers the queue head, advances on handshake
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_rsps.push_back(allocator_predict(pending_reqs.pop_front()));
         end
         if (pending_reqs.size() > 0 &&
             (req_chan.valid && !req_chan.ready || $urandom_range(99) >= send_idle_pct)) begin
            // hold the current word, or present the next one
            req_chan.valid       <= 1'b1;
            req_chan.command     <= pending_reqs[0].command;
            req_chan.size_bytes  <= pending_reqs[0].size_bytes;
            req_chan.byte_offset <= pending_reqs[0].byte_offset;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // long receiver stall, counted here once requested
   always @(posedge clock) begin
      if (reset) begin
         hold_rsp   <= 1'b0;
         hold_count <= 0;
      end else if (hold_count > 0) begin
         hold_count <= hold_count - 1;
         if (hold_count == 1) hold_rsp <= 1'b0;
      end else if (stall_go && !hold_rsp) begin
         hold_rsp   <= 1'b1;
         hold_count <= 400;
      end
   end

   // monitor: checks every accepted response against the oldest prediction
   always @(posedge clock) begin
      rsp_word_t want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected response", 1, 0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_chan.status !== want.status)
                  report_mismatch("status", rsp_chan.status, want.status);
               if (rsp_chan.result_offset !== want.result_offset)
                  report_mismatch("result_offset", rsp_chan.result_offset, want.result_offset);
               if (rsp_chan.chunk_count !== want.chunk_count)
                  report_mismatch("chunk_count", rsp_chan.chunk_count, want.chunk_count);
               if (rsp_chan.zone_empty !== want.zone_empty)
                  report_mismatch("zone_empty", rsp_chan.zone_empty, want.zone_empty);
            end
         end
         rsp_chan.ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog: cycles without any handshake on either side
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_chan.valid || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      int unsigned i;
      used_bits = '0;
      start_bits = '0;
      hint = HEADER_CHUNKS;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: zero size, class limits, bad commands, misalignment
      pending_reqs.push_back(mk(CMD_FREE, 0, HEADER_CHUNKS * CHUNK_BYTES));
      pending_reqs.push_back(mk(CMD_ALLOC, 0, 0));
      pending_reqs.push_back(mk(CMD_ALLOC, MAX_BYTES, 0));
      pending_reqs.push_back(mk(CMD_ALLOC, MAX_BYTES + 1, 0));
      pending_reqs.push_back(mk(CMD_ALLOC, 4095, 16383));
      pending_reqs.push_back(mk(CMD_ALLOC, 1, 0));
      pending_reqs.push_back(mk(CMD_BAD, 4095, 16383));
      pending_reqs.push_back(mk(CMD_FREE, 0, 65));
      pending_reqs.push_back(mk(CMD_RESIZE, 17, 16383));
      pending_reqs.push_back(mk(CMD_FREE, 0, 0));
      pending_reqs.push_back(mk(CMD_FREE, 0, 16368));
      pending_reqs.push_back(mk(CMD_RESIZE, 4095, 64));    // too big: must move
      pending_reqs.push_back(mk(CMD_RESIZE, 32, 80));      // shrink
      pending_reqs.push_back(mk(CMD_RESIZE, 16, 80));      // shrink
      pending_reqs.push_back(mk(CMD_RESIZE, 48, 80));      // grow into freed tail
      pending_reqs.push_back(mk(CMD_RESIZE, MAX_BYTES, 208));
      pending_reqs.push_back(mk(CMD_FREE, 0, 80));
      pending_reqs.push_back(mk(CMD_FREE, 0, 64));
      pending_reqs.push_back(mk(CMD_FREE, 0, 208));
      pending_reqs.push_back(mk(CMD_FREE, 0, 208));         // now empty, then double free
      wait_drained();

      // fill the zone until MAX_BYTES allocations no longer fit so no-space is hit
      for (i = 0; i < 140; i++) pending_reqs.push_back(mk(CMD_ALLOC, MAX_BYTES, 0));
      pending_reqs.push_back(mk(CMD_RESIZE, MAX_BYTES, 16368 - 7 * 16));
      for (i = 0; i < 140; i++)
         pending_reqs.push_back(mk(CMD_FREE, 0, (HEADER_CHUNKS + 8 * i) * CHUNK_BYTES));
      wait_drained();

      // pressure: receiver stalls while requests keep coming
      for (i = 0; i < 20; i++) pending_reqs.push_back(mk(CMD_ALLOC, $urandom_range(64), 0));
      stall_go = 1'b1;
      wait (hold_rsp);
      stall_go = 1'b0;
      wait (!hold_rsp);
      for (i = 0; i < 20; i++)
         pending_reqs.push_back(mk(CMD_FREE, 0, 0));
      wait_drained();
      used_bits = used_bits; // shadow stays authoritative; generator list restarts
      live_offsets.delete();
      for (i = HEADER_CHUNKS; i < NCH; i++) if (start_bits[i]) live_offsets.push_back(i * 16);

      // random phases with different idle mixes
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 63 : 0;
         recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 11 : 0;
         for (i = 0; i < 220; i++) begin
            req_word_t r;
            r = random_req();
            pending_reqs.push_back(r);
            // track the outcome once predicted, by draining in small batches
            if (pending_reqs.size() >= 4) begin
               wait_drained();
               live_offsets.delete();
               for (int j = HEADER_CHUNKS; j < NCH; j++)
                  if (start_bits[j]) live_offsets.push_back(j * 16);
            end
         end
         wait_drained();
      end

      repeat (50) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
